FILE: rtl/hdec_pkg.sv
package hdec_pkg;

    localparam int DEF_MAX_NODES   = 512;
    localparam int DEF_SYMBOL_BITS = 8;
    localparam int IDX_W           = 9;
    localparam int SYM_W           = 8;
    localparam int Q_DEPTH         = 2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_NO_TREE = 2'd2,
        ST_HALTED  = 2'd3
    } t_status;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_BIT  = 1'b1
    } t_op;

    typedef struct packed {
        logic             left_p;
        logic [IDX_W-1:0] left;
        logic             right_p;
        logic [IDX_W-1:0] right;
    } t_links;

    typedef struct packed {
        t_op              op;
        logic             code_bit;
        logic             idx_ok;
        logic [IDX_W-1:0] node_index;
        t_links           links;
        logic [SYM_W-1:0] leaf_symbol;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

    typedef struct packed {
        logic pop;
        logic busy;
    } t_back_ctl;

endpackage

FILE: rtl/hdec_if.sv
interface hdec_in_if import hdec_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic             code_bit;
    logic [IDX_W-1:0] node_index;
    logic             left_present;
    logic [IDX_W-1:0] left_child;
    logic             right_present;
    logic [IDX_W-1:0] right_child;
    logic [SYM_W-1:0] leaf_symbol;

    modport source (
        output valid, op, code_bit, node_index, left_present, left_child,
               right_present, right_child, leaf_symbol,
        input  ready
    );
    modport sink (
        input  valid, op, code_bit, node_index, left_present, left_child,
               right_present, right_child, leaf_symbol,
        output ready
    );
endinterface

interface hdec_out_if import hdec_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             symbol_valid;
    logic [SYM_W-1:0] symbol;
    logic [1:0]       status;

    modport source (
        output valid, symbol_valid, symbol, status,
        input  ready
    );
    modport sink (
        input  valid, symbol_valid, symbol, status,
        output ready
    );
endinterface

FILE: rtl/huffman_tree_bit_decoder_unit.sv
// A result passes through the input queue, the B stage and the output register.
// Throughput: one transaction per cycle unless the output stalls; each code bit that
// steps to a child costs one node table read. A root write (i_cfg_we) holds the back
// end in S_FETCH_RD and S_FETCH_CAP while the root entry is fetched. Reset
// (synchronous, active low) clears all MAX_NODES written flags, with input ready low.
module huffman_tree_bit_decoder_unit import hdec_pkg::*; #(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_wdata,
    hdec_in_if.sink          i_in,
    hdec_out_if.source       o_out
);

    t_head     w_head;
    t_back_ctl w_ctl;

    hdec_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctl   (w_ctl),
        .o_head  (w_head)
    );

    hdec_back #(
        .MAX_NODES   (MAX_NODES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_head      (w_head),
        .o_ctl       (w_ctl),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/hdec_front.sv
module hdec_front import hdec_pkg::*; #(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hdec_in_if.sink   i_in,
    input  t_back_ctl i_ctl,
    output t_head     o_head
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_q [Q_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    t_cmd w_cmd;
    logic w_push;
    logic w_pop;

    always_comb begin
        w_cmd.op            = t_op'(i_in.op);
        w_cmd.code_bit      = i_in.code_bit;
        w_cmd.idx_ok        = (32'(i_in.node_index) < MAX_NODES);
        w_cmd.node_index    = i_in.node_index;
        w_cmd.links.left_p  = i_in.left_present;
        w_cmd.links.left    = i_in.left_child;
        w_cmd.links.right_p = i_in.right_present;
        w_cmd.links.right   = i_in.right_child;
        w_cmd.leaf_symbol   = i_in.leaf_symbol;
    end

    assign i_in.ready = (r_cnt != CNT_W'(Q_DEPTH)) && !i_ctl.busy;
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_ctl.pop;

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

FILE: rtl/hdec_back.sv
module hdec_back import hdec_pkg::*; #(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_wdata,
    input  t_head            i_head,
    output t_back_ctl        o_ctl,
    hdec_out_if.source       o_out
);

    localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    typedef struct packed {
        t_links                 links;
        logic [SYMBOL_BITS-1:0] sym;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR     = 4'b0001,
        S_RUN       = 4'b0010,
        S_FETCH_RD  = 4'b0100,
        S_FETCH_CAP = 4'b1000
    } t_state;

    t_entry r_mem  [MAX_NODES];
    logic   r_wmem [MAX_NODES];
    t_entry r_rd_ent;
    logic   r_rd_wr;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [IDX_W-1:0]  r_root;
    t_entry            r_root_ent;
    logic              r_root_ok;
    t_entry            r_cur_ent;
    logic              r_cur_ok;
    logic              r_halt;

    logic    r_b_valid;
    logic    r_b_read;
    t_status r_b_status;

    logic             r_out_valid;
    logic             r_out_sym_valid;
    logic [SYM_W-1:0] r_out_sym;
    t_status          r_out_status;

    logic              w_adv;
    logic              w_pop;
    logic              w_b_leaf;
    logic              w_fetch_ok;
    t_cmd              w_cmd;
    t_entry            w_new_ent;
    logic              w_load_root;

    t_entry            e_cur;
    logic              e_ok;
    logic              e_halt;

    logic              w_child_p;
    logic [IDX_W-1:0]  w_child;
    logic              w_child_ok;
    t_entry            n_root_ent;
    logic              n_root_ok;
    t_entry            a_cur;
    logic              a_ok;
    logic              a_halt;
    logic              a_read;
    t_status           a_status;

    logic              b_sym_valid;
    logic [SYM_W-1:0]  b_sym;
    t_status           b_status;

    logic              w_mem_we;
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_wmem_we;
    logic [ADDR_W-1:0] w_wmem_addr;
    logic              w_wmem_data;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_pop      = (r_state == S_RUN) && w_adv && i_head.valid;
    assign w_cmd      = i_head.cmd;
    assign w_new_ent  = '{links: w_cmd.links, sym: SYMBOL_BITS'(w_cmd.leaf_symbol)};
    assign w_load_root = w_cmd.idx_ok && (w_cmd.node_index == r_root);
    assign w_b_leaf   = !r_rd_ent.links.left_p && !r_rd_ent.links.right_p;
    assign w_fetch_ok = (32'(r_root) < MAX_NODES) && r_rd_wr;

    // walk state as seen by the next transaction, folding in the read in flight
    always_comb begin
        e_cur  = r_cur_ent;
        e_ok   = r_cur_ok;
        e_halt = r_halt;
        if (r_b_valid && r_b_read) begin
            if (!r_rd_wr) begin
                e_halt = 1'b1;
            end else if (w_b_leaf) begin
                e_cur  = r_root_ent;
                e_ok   = r_root_ok;
                e_halt = 1'b0;
            end else begin
                e_cur  = r_rd_ent;
                e_ok   = 1'b1;
                e_halt = 1'b0;
            end
        end
    end

    always_comb begin
        w_child_p  = w_cmd.code_bit ? e_cur.links.right_p : e_cur.links.left_p;
        w_child    = w_cmd.code_bit ? e_cur.links.right : e_cur.links.left;
        w_child_ok = (32'(w_child) < MAX_NODES);
        n_root_ent = r_root_ent;
        n_root_ok  = r_root_ok;
        a_cur      = e_cur;
        a_ok       = e_ok;
        a_halt     = e_halt;
        a_read     = 1'b0;
        a_status   = ST_OK;
        if (w_pop) begin
            if (w_cmd.op == OP_LOAD) begin
                if (w_load_root) begin
                    n_root_ent = w_new_ent;
                    n_root_ok  = 1'b1;
                end
                a_cur  = n_root_ent;
                a_ok   = n_root_ok;
                a_halt = 1'b0;
            end else if (e_halt) begin
                a_status = ST_HALTED;
            end else if (!e_ok) begin
                a_status = ST_NO_TREE;
                a_halt   = 1'b1;
            end else if (!w_child_p || !w_child_ok) begin
                a_status = ST_MISSING;
                a_halt   = 1'b1;
            end else begin
                a_read = 1'b1;
            end
        end
    end

    always_comb begin
        b_sym_valid = 1'b0;
        b_sym       = '0;
        b_status    = r_b_status;
        if (r_b_read) begin
            if (!r_rd_wr) begin
                b_status = ST_MISSING;
            end else if (w_b_leaf) begin
                b_sym_valid = 1'b1;
                b_sym       = SYM_W'(r_rd_ent.sym);
                b_status    = ST_OK;
            end else begin
                b_status = ST_OK;
            end
        end
    end

    always_comb begin
        w_mem_we  = w_pop && (w_cmd.op == OP_LOAD) && w_cmd.idx_ok;
        w_wr_addr = ADDR_W'(w_cmd.node_index);
        if (r_state == S_CLEAR) begin
            w_wmem_we   = 1'b1;
            w_wmem_addr = r_clr_addr;
            w_wmem_data = 1'b0;
        end else begin
            w_wmem_we   = w_mem_we;
            w_wmem_addr = w_wr_addr;
            w_wmem_data = 1'b1;
        end
        w_rd_en   = (w_pop && a_read) || (r_state == S_FETCH_RD);
        w_rd_addr = (r_state == S_FETCH_RD) ? ADDR_W'(r_root) : ADDR_W'(w_child);
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_new_ent;
        end
        if (w_rd_en) begin
            r_rd_ent <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wmem_we) begin
            r_wmem[w_wmem_addr] <= w_wmem_data;
        end
        if (w_rd_en) begin
            r_rd_wr <= r_wmem[w_rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'(MAX_NODES - 1)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_cfg_we) begin
                    n_state = S_FETCH_RD;
                end
            end
            S_FETCH_RD: begin
                n_state = i_cfg_we ? S_FETCH_RD : S_FETCH_CAP;
            end
            S_FETCH_CAP: begin
                n_state = i_cfg_we ? S_FETCH_RD : S_RUN;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_root      <= '0;
            r_root_ok   <= 1'b0;
            r_cur_ok    <= 1'b0;
            r_halt      <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata;
            end
            if (r_state == S_FETCH_CAP) begin
                r_root_ok <= w_fetch_ok;
                r_cur_ok  <= w_fetch_ok;
            end else if (w_adv) begin
                r_root_ok <= n_root_ok;
                r_cur_ok  <= a_ok;
                r_halt    <= a_halt;
            end
            if (w_adv) begin
                r_b_valid   <= w_pop;
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH_CAP) begin
            r_root_ent <= r_rd_ent;
            r_cur_ent  <= r_rd_ent;
        end else if (w_adv) begin
            r_root_ent <= n_root_ent;
            r_cur_ent  <= a_cur;
        end
        if (w_adv) begin
            r_b_read        <= a_read;
            r_b_status      <= a_status;
            r_out_sym_valid <= b_sym_valid;
            r_out_sym       <= b_sym;
            r_out_status    <= b_status;
        end
    end

    assign o_ctl.pop  = w_pop;
    assign o_ctl.busy = (r_state == S_CLEAR);

    assign o_out.valid        = r_out_valid;
    assign o_out.symbol_valid = r_out_sym_valid;
    assign o_out.symbol       = r_out_sym;
    assign o_out.status       = r_out_status;

endmodule

FILE: verif/huffman_tree_bit_decoder_unit_tb.sv
module huffman_tree_bit_decoder_unit_tb;
    import hdec_pkg::*;

    localparam int NODES        = DEF_MAX_NODES;
    localparam int RANDOM_ITEMS = 850;
    localparam int MAX_TREE     = 32;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        t_op              op;
        logic             code_bit;
        logic [IDX_W-1:0] node_index;
        logic             left_present;
        logic [IDX_W-1:0] left_child;
        logic             right_present;
        logic [IDX_W-1:0] right_child;
        logic [SYM_W-1:0] leaf_symbol;
    } t_item;

    typedef struct {
        logic             has_sym;
        logic [SYM_W-1:0] sym;
        t_status          status;
    } t_decoded;

    typedef enum {ROW_ITEM, ROW_ROOT} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_item            it;
        logic [IDX_W-1:0] root;
        bit               typed;
        t_decoded         want;
    } t_row;

    typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PATTERN} t_stall;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_wdata;

    hdec_in_if  in_if ();
    hdec_out_if out_if ();

    huffman_tree_bit_decoder_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // tree table as the decoder should see it
    logic             tbl_lp      [NODES];
    logic [IDX_W-1:0] tbl_left    [NODES];
    logic             tbl_rp      [NODES];
    logic [IDX_W-1:0] tbl_right   [NODES];
    logic [SYM_W-1:0] tbl_sym     [NODES];
    bit               tbl_written [NODES];
    logic [IDX_W-1:0] walk_node;
    logic [IDX_W-1:0] root_reg;
    bit               walk_halted;

    t_decoded decoded_q [$];
    t_row     directed  [$];

    int     mismatches  = 0;
    int     items_sent  = 0;
    int     burst_left  = 0;
    int     cycles      = 0;
    int     mode_left   = 0;
    t_stall stall_mode  = STALL_NONE;
    bit [7:0] stall_pat = 8'h01;

    always #5 clk = ~clk;

    function automatic t_decoded predict_decode(input t_item it);
        t_decoded         r;
        logic             pres;
        logic [IDX_W-1:0] nxt;
        r.has_sym = 1'b0;
        r.sym     = '0;
        r.status  = ST_OK;
        if (it.op == OP_LOAD) begin
            tbl_lp[it.node_index]      = it.left_present;
            tbl_left[it.node_index]    = it.left_child;
            tbl_rp[it.node_index]      = it.right_present;
            tbl_right[it.node_index]   = it.right_child;
            tbl_sym[it.node_index]     = it.leaf_symbol;
            tbl_written[it.node_index] = 1'b1;
            walk_halted = 1'b0;
            walk_node   = root_reg;
        end else if (walk_halted) begin
            r.status = ST_HALTED;
        end else if (!tbl_written[walk_node]) begin
            walk_halted = 1'b1;
            r.status    = ST_NO_TREE;
        end else begin
            pres = it.code_bit ? tbl_rp[walk_node] : tbl_lp[walk_node];
            nxt  = it.code_bit ? tbl_right[walk_node] : tbl_left[walk_node];
            if (!pres || !tbl_written[nxt]) begin
                walk_halted = 1'b1;
                r.status    = ST_MISSING;
            end else if (!tbl_lp[nxt] && !tbl_rp[nxt]) begin
                walk_node = root_reg;
                r.has_sym = 1'b1;
                r.sym     = tbl_sym[nxt];
            end else begin
                walk_node = nxt;
            end
        end
        return r;
    endfunction

    function automatic t_item rand_item(input t_op op);
        t_item it;
        it.op            = op;
        it.code_bit      = 1'($urandom_range(0, 1));
        it.node_index    = IDX_W'($urandom_range(0, NODES - 1));
        it.left_present  = 1'($urandom_range(0, 1));
        it.left_child    = IDX_W'($urandom_range(0, NODES - 1));
        it.right_present = 1'($urandom_range(0, 1));
        it.right_child   = IDX_W'($urandom_range(0, NODES - 1));
        it.leaf_symbol   = SYM_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic void row_load(input logic [IDX_W-1:0] idx, input logic lp,
                                     input logic [IDX_W-1:0] lc, input logic rp,
                                     input logic [IDX_W-1:0] rc, input logic [SYM_W-1:0] sym);
        t_row r;
        r.kind             = ROW_ITEM;
        r.it               = rand_item(OP_LOAD);
        r.it.node_index    = idx;
        r.it.left_present  = lp;
        r.it.left_child    = lc;
        r.it.right_present = rp;
        r.it.right_child   = rc;
        r.it.leaf_symbol   = sym;
        r.root             = '0;
        r.typed            = 1'b1;
        r.want.has_sym     = 1'b0;
        r.want.sym         = '0;
        r.want.status      = ST_OK;
        directed.insert(directed.size(), r);
    endfunction

    function automatic void row_bit(input logic b, input bit typed, input logic has,
                                    input logic [SYM_W-1:0] sym, input t_status st);
        t_row r;
        r.kind         = ROW_ITEM;
        r.it           = rand_item(OP_BIT);
        r.it.code_bit  = b;
        r.root         = '0;
        r.typed        = typed;
        r.want.has_sym = has;
        r.want.sym     = sym;
        r.want.status  = st;
        directed.insert(directed.size(), r);
    endfunction

    function automatic void row_root(input logic [IDX_W-1:0] idx);
        t_row r;
        r.kind         = ROW_ROOT;
        r.it           = rand_item(OP_BIT);
        r.root         = idx;
        r.typed        = 1'b0;
        r.want.has_sym = 1'b0;
        r.want.sym     = '0;
        r.want.status  = ST_OK;
        directed.insert(directed.size(), r);
    endfunction

    task automatic send_item(input t_item it, input bit typed, input t_decoded want);
        int       gap;
        t_decoded got;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                in_if.valid = 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_if.valid         = 1'b1;
        in_if.op            = it.op;
        in_if.code_bit      = it.code_bit;
        in_if.node_index    = it.node_index;
        in_if.left_present  = it.left_present;
        in_if.left_child    = it.left_child;
        in_if.right_present = it.right_present;
        in_if.right_child   = it.right_child;
        in_if.leaf_symbol   = it.leaf_symbol;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        got = predict_decode(it);
        decoded_q.insert(decoded_q.size(), typed ? want : got);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_if.valid = 1'b0;
        while (decoded_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_root(input logic [IDX_W-1:0] idx);
        wait_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = idx;
        root_reg  = idx;
        walk_node = idx;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // receiver stalls
    always @(negedge clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
            stall_pat  = 8'($urandom_range(1, 255));
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:  out_if.ready = 1'b1;
            STALL_HALF:  out_if.ready = 1'($urandom_range(0, 1));
            STALL_HEAVY: out_if.ready = ($urandom_range(0, 3) == 0);
            default: begin
                out_if.ready = stall_pat[0];
                stall_pat    = {stall_pat[0], stall_pat[7:1]};
            end
        endcase
    end

    always @(posedge clk) begin : result_check
        t_decoded want;
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (decoded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: valid=%0b sym=%02h status=%0d",
                             out_if.symbol_valid, out_if.symbol, out_if.status);
            end else begin
                want = decoded_q.pop_front();
                if (out_if.symbol_valid !== want.has_sym || out_if.symbol !== want.sym ||
                    out_if.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0b/%02h/%0d got %0b/%02h/%0d",
                                 want.has_sym, want.sym, want.status,
                                 out_if.symbol_valid, out_if.symbol, out_if.status);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("huffman_tree_bit_decoder_unit regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_decoded         dummy;
        t_item            node_items [MAX_TREE];
        t_item            tmp;
        logic [IDX_W-1:0] tr_idx  [MAX_TREE];
        bit               tr_leaf [MAX_TREE];
        int               tr_l    [MAX_TREE];
        int               tr_r    [MAX_TREE];
        bit               used    [NODES];
        int               base, n, n_nodes, n_leaves, target, p, k, cand, pick;
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        in_if.valid          = 1'b0;
        in_if.op             = OP_LOAD;
        in_if.code_bit       = 1'b0;
        in_if.node_index     = '0;
        in_if.left_present   = 1'b0;
        in_if.left_child     = '0;
        in_if.right_present  = 1'b0;
        in_if.right_child    = '0;
        in_if.leaf_symbol    = '0;
        out_if.ready         = 1'b0;
        root_reg             = '0;
        walk_node            = '0;
        walk_halted          = 1'b0;
        dummy.has_sym        = 1'b0;
        dummy.sym            = '0;
        dummy.status         = ST_OK;
        for (int i = 0; i < NODES; i++) tbl_written[i] = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // unwritten root after reset, then halted
        row_bit(1'b0, 1'b1, 1'b0, 8'h00, ST_NO_TREE);
        row_bit(1'b1, 1'b1, 1'b0, 8'h00, ST_HALTED);
        row_load(9'd0,   1'b1, 9'd1,   1'b1, 9'd2,   8'h5A);
        row_load(9'd1,   1'b0, 9'd0,   1'b0, 9'd0,   8'h00);
        row_load(9'd2,   1'b1, 9'd3,   1'b1, 9'd511, 8'h00);
        row_load(9'd3,   1'b0, 9'd511, 1'b0, 9'd511, 8'hFF);
        row_load(9'd511, 1'b0, 9'd0,   1'b0, 9'd0,   8'hA5);
        row_bit(1'b0, 1'b1, 1'b1, 8'h00, ST_OK);
        row_bit(1'b1, 1'b1, 1'b0, 8'h00, ST_OK);
        row_bit(1'b0, 1'b1, 1'b1, 8'hFF, ST_OK);
        row_bit(1'b1, 1'b1, 1'b0, 8'h00, ST_OK);
        row_bit(1'b1, 1'b1, 1'b1, 8'hA5, ST_OK);
        row_bit(1'b1, 1'b1, 1'b0, 8'h00, ST_OK);
        // load mid-walk restarts at root
        row_load(9'd4,   1'b0, 9'd0,   1'b1, 9'd5,   8'h3C);
        row_bit(1'b0, 1'b1, 1'b1, 8'h00, ST_OK);
        row_bit(1'b1, 1'b1, 1'b0, 8'h00, ST_OK);
        row_root(9'd0);
        row_bit(1'b0, 1'b1, 1'b1, 8'h00, ST_OK);
        // absent child, then halted; root write keeps the halt
        row_root(9'd4);
        row_bit(1'b0, 1'b1, 1'b0, 8'h00, ST_MISSING);
        row_bit(1'b0, 1'b1, 1'b0, 8'h00, ST_HALTED);
        row_root(9'd0);
        row_bit(1'b0, 1'b1, 1'b0, 8'h00, ST_HALTED);
        // child present but never written
        row_root(9'd4);
        row_load(9'd1,   1'b0, 9'd0,   1'b0, 9'd0,   8'h00);
        row_bit(1'b1, 1'b1, 1'b0, 8'h00, ST_MISSING);
        // leaf as root, then an unwritten root
        row_root(9'd1);
        row_load(9'd3,   1'b0, 9'd511, 1'b0, 9'd511, 8'hFF);
        row_bit(1'b1, 1'b1, 1'b0, 8'h00, ST_MISSING);
        row_root(9'd510);
        row_load(9'd3,   1'b0, 9'd511, 1'b0, 9'd511, 8'hFF);
        row_bit(1'b0, 1'b1, 1'b0, 8'h00, ST_NO_TREE);
        // self loop at the top index
        row_root(9'd511);
        row_load(9'd511, 1'b1, 9'd511, 1'b1, 9'd511, 8'hFF);
        row_bit(1'b1, 1'b0, 1'b0, 8'h00, ST_OK);
        row_bit(1'b0, 1'b0, 1'b0, 8'h00, ST_OK);
        row_root(9'd0);
        row_bit(1'b1, 1'b0, 1'b0, 8'h00, ST_OK);
        row_bit(1'b1, 1'b0, 1'b0, 8'h00, ST_OK);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_ROOT)
                set_root(directed[i].root);
            else
                send_item(directed[i].it, directed[i].typed, directed[i].want);
        end

        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                // noise: arbitrary root and arbitrary transactions
                set_root(IDX_W'($urandom_range(0, NODES - 1)));
                n = $urandom_range(8, 30);
                repeat (n) send_item(rand_item(t_op'($urandom_range(0, 1))), 1'b0, dummy);
            end else begin
                for (int i = 0; i < NODES; i++) used[i] = 1'b0;
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    tr_idx[0] = '0;
                else if (pick == 1)
                    tr_idx[0] = IDX_W'(NODES - 1);
                else
                    tr_idx[0] = IDX_W'($urandom_range(0, NODES - 1));
                used[tr_idx[0]] = 1'b1;
                tr_leaf[0] = 1'b1;
                n_nodes    = 1;
                n_leaves   = 1;
                target     = $urandom_range(2, 12);
                while (n_leaves < target) begin
                    do p = $urandom_range(0, n_nodes - 1); while (!tr_leaf[p]);
                    for (k = 0; k < 2; k++) begin
                        do cand = $urandom_range(0, NODES - 1); while (used[cand]);
                        used[cand]       = 1'b1;
                        tr_idx[n_nodes]  = IDX_W'(cand);
                        tr_leaf[n_nodes] = 1'b1;
                        if (k == 0) tr_l[p] = n_nodes;
                        else        tr_r[p] = n_nodes;
                        n_nodes++;
                    end
                    tr_leaf[p] = 1'b0;
                    n_leaves++;
                end
                for (int i = 0; i < n_nodes; i++) begin
                    node_items[i]               = rand_item(OP_LOAD);
                    node_items[i].node_index    = tr_idx[i];
                    node_items[i].left_present  = !tr_leaf[i];
                    node_items[i].right_present = !tr_leaf[i];
                    if (!tr_leaf[i]) begin
                        node_items[i].left_child  = tr_idx[tr_l[i]];
                        node_items[i].right_child = tr_idx[tr_r[i]];
                    end
                end
                // occasionally break one entry
                if ($urandom_range(0, 5) == 0) begin
                    p = $urandom_range(0, n_nodes - 1);
                    case ($urandom_range(0, 2))
                        0:       node_items[p].left_present  = 1'b0;
                        1:       node_items[p].right_present = 1'b0;
                        default: node_items[p].left_child    = IDX_W'($urandom_range(0, NODES - 1));
                    endcase
                end
                for (int i = n_nodes - 1; i > 0; i--) begin
                    k             = $urandom_range(0, i);
                    tmp           = node_items[i];
                    node_items[i] = node_items[k];
                    node_items[k] = tmp;
                end
                set_root(tr_idx[0]);
                for (int i = 0; i < n_nodes; i++) send_item(node_items[i], 1'b0, dummy);
                n = $urandom_range(10, 60);
                repeat (n) begin
                    if ($urandom_range(0, 24) == 0)
                        send_item(rand_item(t_op'($urandom_range(0, 1))), 1'b0, dummy);
                    else
                        send_item(rand_item(OP_BIT), 1'b0, dummy);
                end
            end
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("huffman_tree_bit_decoder_unit regression: pass");
        else
            $display("huffman_tree_bit_decoder_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/hdec_pkg.sv
rtl/hdec_if.sv
rtl/hdec_front.sv
rtl/hdec_back.sv
rtl/huffman_tree_bit_decoder_unit.sv
verif/huffman_tree_bit_decoder_unit_tb.sv
